// ===== rtl/core/sifl_pkg.sv =====
// ----------------------------------------------------------------------------
// sifl_pkg
// Shared sizes, codes and types of the session id free list.
// ----------------------------------------------------------------------------
package sifl_pkg;

    // pool geometry
    localparam int POOL_SIZE = 1024;
    localparam int ID_W      = $clog2(POOL_SIZE);
    localparam int FREE_W    = $clog2(POOL_SIZE + 1);
    localparam int LANE_W    = 8;
    localparam int CONN_W    = 16;
    localparam int TOT_W     = 32;

    localparam logic [ID_W-1:0]   LAST_SLOT  = ID_W'(POOL_SIZE - 1);
    localparam logic [FREE_W-1:0] FREE_FULL  = FREE_W'(POOL_SIZE);
    localparam logic [15:0]       SID_LIMIT  = 16'(POOL_SIZE);
    localparam logic [CONN_W-1:0] CONN_MAX   = '1;

    // stream word widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 152;
    localparam int M_PAD_W   = M_TDATA_W - (3 + ID_W + LANE_W + 1 + FREE_W + CONN_W + 3 * TOT_W);

    // actions
    localparam logic [2:0] ACT_ACQUIRE = 3'd0;
    localparam logic [2:0] ACT_RELEASE = 3'd1;
    localparam logic [2:0] ACT_CONNECT = 3'd2;
    localparam logic [2:0] ACT_QUERY   = 3'd3;
    localparam logic [2:0] ACT_CLOSE   = 3'd4;

    // result status
    localparam logic [2:0] STS_OK            = 3'd0;
    localparam logic [2:0] STS_EMPTY         = 3'd1;
    localparam logic [2:0] STS_BAD_ID        = 3'd2;
    localparam logic [2:0] STS_NOT_RELEASING = 3'd3;
    localparam logic [2:0] STS_ALREADY_FREE  = 3'd4;
    localparam logic [2:0] STS_NOT_READY     = 3'd5;

    // disconnect reasons
    localparam logic [2:0] RSN_NORMAL  = 3'd1;
    localparam logic [2:0] RSN_ERROR   = 3'd2;
    localparam logic [2:0] RSN_RETRANS = 3'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_POOL_ENABLED = 8'd0;
    localparam logic [7:0] CFG_WORKER_COUNT = 8'd1;

    // counter update request for one step
    typedef struct packed {
        logic connect;
        logic close_all;
        logic disconnect;
        logic retrans;
    } sifl_stat_op_t;

    // counter values
    typedef struct packed {
        logic [CONN_W-1:0] connected;
        logic [TOT_W-1:0]  total_conn;
        logic [TOT_W-1:0]  total_disc;
        logic [TOT_W-1:0]  retrans;
    } sifl_stat_t;

endpackage

// ===== rtl/core/sifl_lane_mod.sv =====
// ----------------------------------------------------------------------------
// sifl_lane_mod
// Bit-serial remainder unit: id modulo worker count, one dividend bit a cycle.
// ----------------------------------------------------------------------------
module sifl_lane_mod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sifl_pkg::ID_W-1:0]    dividend,
    input  logic [sifl_pkg::LANE_W-1:0]  divisor,
    output logic                         done,
    output logic [sifl_pkg::LANE_W-1:0]  lane
);

    localparam int CNT_W = $clog2(sifl_pkg::ID_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [sifl_pkg::ID_W-1:0]   shift_reg;
    logic [sifl_pkg::LANE_W-1:0] rem_reg;
    logic [sifl_pkg::LANE_W-1:0] div_reg;
    logic [sifl_pkg::LANE_W:0]   trial;
    logic [sifl_pkg::LANE_W-1:0] rem_next;

    // one restoring step
    always_comb begin
        trial = {rem_reg, shift_reg[sifl_pkg::ID_W-1]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = sifl_pkg::LANE_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[sifl_pkg::LANE_W-1:0];
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(sifl_pkg::ID_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[sifl_pkg::ID_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    // zero lane count gives lane zero
    assign lane = (div_reg == '0) ? '0 : rem_reg;

`ifndef ASSERT_OFF
    // remainder always below the divisor
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && (div_reg != '0) |-> rem_reg < div_reg)
        else $error("lane remainder out of range");
`endif

endmodule

// ===== rtl/core/sifl_stats.sv =====
// ----------------------------------------------------------------------------
// sifl_stats
// Connection counters: saturating connected count and wrapping totals.
// ----------------------------------------------------------------------------
module sifl_stats (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    op_valid,
    input  sifl_pkg::sifl_stat_op_t op,
    output sifl_pkg::sifl_stat_t    stat
);

    sifl_pkg::sifl_stat_t stat_reg;
    sifl_pkg::sifl_stat_t stat_next;

    // next counter values
    always_comb begin
        stat_next = stat_reg;
        if (op_valid) begin
            if (op.close_all) begin
                stat_next.connected = '0;
            end else if (op.connect) begin
                if (stat_reg.connected != sifl_pkg::CONN_MAX) begin
                    stat_next.connected = stat_reg.connected + 1'b1;
                end
                stat_next.total_conn = stat_reg.total_conn + 1'b1;
            end else if (op.disconnect) begin
                if (stat_reg.connected != '0) begin
                    stat_next.connected = stat_reg.connected - 1'b1;
                end
                stat_next.total_disc = stat_reg.total_disc + 1'b1;
                if (op.retrans) begin
                    stat_next.retrans = stat_reg.retrans + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_reg <= '0;
        end else begin
            stat_reg <= stat_next;
        end
    end

    assign stat = stat_reg;

endmodule

// ===== rtl/core/session_id_free_list_top.sv =====
// ----------------------------------------------------------------------------
// session_id_free_list_top
// Session id allocator: FIFO free list and free bitmap in block memories.
// An accepted word passes the execute and done states, a granted acquire also
// the divide state (the lane remainder takes one id bit per cycle); a new word
// is taken only in the idle state, once the last result word is registered.
// Reset: a sweep over every slot loads the list with ids 0 upward and marks all
// ids free; no word is taken during it, configuration writes are.
// ----------------------------------------------------------------------------
module session_id_free_list_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // fields from bit 0: session_id[15:0], session_releasing, disc_reason[2:0], pad
    input  logic [sifl_pkg::S_TDATA_W-1:0]    s_tdata,
    // fields from bit 0: action[2:0]
    input  logic [sifl_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: status[2:0], granted_id[9:0], worker_lane[7:0], id_is_free,
    // free_count[10:0], connected_count[15:0], total_connected[31:0],
    // total_disconnected[31:0], retrans_disconnected[31:0], pad
    output logic [sifl_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [7:0]                        cfg_index,
    input  logic [7:0]                        cfg_data
);

    localparam int ID_W = sifl_pkg::ID_W;

    typedef enum logic [4:0] {
        ST_INIT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_EXEC = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } sifl_state_t;

    sifl_state_t state_reg, state_next;

    logic                        pool_en_reg;
    logic [7:0]                  workers_reg;
    logic [ID_W-1:0]             init_idx_reg;
    logic [ID_W-1:0]             head_reg, head_next;
    logic [ID_W-1:0]             tail_reg, tail_next;
    logic [sifl_pkg::FREE_W-1:0] free_total_reg, free_total_next;

    logic [2:0]                  act_reg;
    logic [15:0]                 sid_reg;
    logic                        releasing_reg;
    logic [2:0]                  reason_reg;

    logic [2:0]                  status_reg, status_next;
    logic [ID_W-1:0]             granted_reg, granted_next;
    logic [sifl_pkg::LANE_W-1:0] lane_reg;
    logic                        is_free_reg, is_free_next;

    logic                        m_tvalid_reg;
    logic [sifl_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [ID_W-1:0]             q_mem [sifl_pkg::POOL_SIZE];
    logic                        map_mem [sifl_pkg::POOL_SIZE];
    logic [ID_W-1:0]             q_rdata_reg;
    logic                        map_rdata_reg;
    logic [ID_W-1:0]             map_raddr;

    logic                        q_we, map_we, map_wdata;
    logic [ID_W-1:0]             q_waddr, q_wdata, map_waddr;

    logic                        s_accept, out_free;
    logic                        acq_ok, rel_ok, sid_bad;
    logic                        lane_start, lane_done;
    logic [sifl_pkg::LANE_W-1:0] lane_val;

    logic                        stat_valid;
    sifl_pkg::sifl_stat_op_t     stat_op;
    sifl_pkg::sifl_stat_t        stat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_en_reg <= 1'b1;
            workers_reg <= 8'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                sifl_pkg::CFG_POOL_ENABLED: pool_en_reg <= cfg_data[0];
                sifl_pkg::CFG_WORKER_COUNT: workers_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // step decision from the latched word and the memory read data
    assign sid_bad = (sid_reg >= sifl_pkg::SID_LIMIT);
    assign acq_ok  = (act_reg == sifl_pkg::ACT_ACQUIRE) && pool_en_reg
                     && (free_total_reg != '0);
    assign rel_ok  = (act_reg == sifl_pkg::ACT_RELEASE) && !sid_bad && releasing_reg
                     && !map_rdata_reg;

    always_comb begin
        status_next  = sifl_pkg::STS_OK;
        granted_next = '0;
        is_free_next = 1'b0;
        case (act_reg)
            sifl_pkg::ACT_ACQUIRE: begin
                if (!pool_en_reg) begin
                    status_next = sifl_pkg::STS_NOT_READY;
                end else if (free_total_reg == '0) begin
                    status_next = sifl_pkg::STS_EMPTY;
                end else begin
                    granted_next = q_rdata_reg;
                end
            end
            sifl_pkg::ACT_RELEASE: begin
                if (sid_bad) begin
                    status_next = sifl_pkg::STS_BAD_ID;
                end else if (!releasing_reg) begin
                    status_next = sifl_pkg::STS_NOT_RELEASING;
                end else if (map_rdata_reg) begin
                    status_next = sifl_pkg::STS_ALREADY_FREE;
                end
            end
            sifl_pkg::ACT_QUERY: begin
                is_free_next = !sid_bad && map_rdata_reg;
            end
            default: ;
        endcase
    end

    // list pointers and free count
    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_total_next = free_total_reg;
        if (state_reg == ST_EXEC) begin
            if (acq_ok) begin
                head_next       = (head_reg == sifl_pkg::LAST_SLOT) ? '0 : head_reg + 1'b1;
                free_total_next = free_total_reg - 1'b1;
            end else if (rel_ok) begin
                tail_next       = (tail_reg == sifl_pkg::LAST_SLOT) ? '0 : tail_reg + 1'b1;
                free_total_next = free_total_reg + 1'b1;
            end
        end
    end

    // memory write ports: reset sweep or step write-back
    always_comb begin
        if (state_reg == ST_INIT) begin
            q_we      = 1'b1;
            q_waddr   = init_idx_reg;
            q_wdata   = init_idx_reg;
            map_we    = 1'b1;
            map_waddr = init_idx_reg;
            map_wdata = 1'b1;
        end else begin
            q_we      = (state_reg == ST_EXEC) && rel_ok;
            q_waddr   = tail_reg;
            q_wdata   = sid_reg[ID_W-1:0];
            map_we    = (state_reg == ST_EXEC) && (acq_ok || rel_ok);
            map_waddr = acq_ok ? q_rdata_reg : sid_reg[ID_W-1:0];
            map_wdata = rel_ok;
        end
    end

    assign map_raddr = s_tdata[ID_W-1:0];

    // free list memory, read at the head
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= q_mem[head_reg];
    end

    // free bitmap memory, read at the incoming id
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: if (init_idx_reg == sifl_pkg::LAST_SLOT) state_next = ST_IDLE;
            ST_IDLE: if (s_accept) state_next = ST_EXEC;
            ST_EXEC: state_next = acq_ok ? ST_DIV : ST_DONE;
            ST_DIV:  if (lane_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            init_idx_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_total_reg <= sifl_pkg::FREE_FULL;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_total_reg <= free_total_next;
            if (state_reg == ST_INIT) begin
                init_idx_reg <= init_idx_reg + 1'b1;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // input word and step result registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg       <= s_tuser;
            sid_reg       <= s_tdata[15:0];
            releasing_reg <= s_tdata[16];
            reason_reg    <= s_tdata[19:17];
        end
        if (state_reg == ST_EXEC) begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            is_free_reg <= is_free_next;
            lane_reg    <= '0;
        end else if ((state_reg == ST_DIV) && lane_done) begin
            lane_reg <= lane_val;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= {{sifl_pkg::M_PAD_W{1'b0}}, stat.retrans, stat.total_disc,
                            stat.total_conn, stat.connected, free_total_reg,
                            is_free_reg, lane_reg, granted_reg, status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // lane remainder
    assign lane_start = (state_reg == ST_EXEC) && acq_ok;

    sifl_lane_mod u_lane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lane_start),
        .dividend (q_rdata_reg),
        .divisor  (workers_reg),
        .done     (lane_done),
        .lane     (lane_val)
    );

    // connection counters
    assign stat_valid        = (state_reg == ST_EXEC);
    assign stat_op.connect   = (act_reg == sifl_pkg::ACT_CONNECT);
    assign stat_op.close_all = (act_reg == sifl_pkg::ACT_CLOSE);
    assign stat_op.disconnect = rel_ok && ((reason_reg == sifl_pkg::RSN_NORMAL)
                                || (reason_reg == sifl_pkg::RSN_ERROR)
                                || (reason_reg == sifl_pkg::RSN_RETRANS));
    assign stat_op.retrans   = (reason_reg == sifl_pkg::RSN_RETRANS);

    sifl_stats u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (stat_valid),
        .op       (stat_op),
        .stat     (stat)
    );

`ifndef ASSERT_OFF
    // free count never above the pool size
    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_total_reg <= sifl_pkg::FREE_FULL)
        else $error("free count above pool size");

    // empty or full list has head and tail together
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_total_reg == '0) || (free_total_reg == sifl_pkg::FREE_FULL)
        |-> head_reg == tail_reg)
        else $error("list pointers disagree with free count");

    // lane unit finishes only while waiting for it
    a_lane_done: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done |-> state_reg == ST_DIV)
        else $error("lane result outside divide wait");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the session id free list. A tracker class mirrors
// the free ring, the free bitmap and the connection counters, predicts one
// result word per accepted request word and checks each result word in
// order. Stimulus runs a directed opening, random bursts under several
// settings, a disabled pool and a shuffled hand-back of every held id,
// with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import sifl_pkg::*;

    localparam int     CLK_HALF        = 10;
    localparam int     RESET_CYCLES    = 2;
    localparam int     SETTLE_CYCLES   = 16;    // longest result latency plus margin
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     IDLE_PERCENT    = 8;
    localparam longint RUN_LIMIT       = 64'd50_000_000;
    localparam int     S_PAD_W         = S_TDATA_W - 20;

    // codes the package leaves unnamed
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
    localparam logic [2:0] RSN_NONE        = 3'd0;
    localparam logic [2:0] RSN_ABORT       = 3'd4;
    localparam logic [2:0] RSN_BAD_LAST    = 3'd7;

    // request word, fields from bit 0: sid, releasing, reason, pad
    typedef struct packed {
        logic [S_PAD_W-1:0] pad;
        logic [2:0]         reason;
        logic               releasing;
        logic [15:0]        sid;
    } sess_word_t;

    typedef struct {
        logic [2:0] action;
        sess_word_t body;
    } sess_req_t;

    // result word, first field in the lowest bits
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic [TOT_W-1:0]   retrans_disconnected;
        logic [TOT_W-1:0]   total_disconnected;
        logic [TOT_W-1:0]   total_connected;
        logic [CONN_W-1:0]  connected_count;
        logic [FREE_W-1:0]  free_count;
        logic               id_is_free;
        logic [LANE_W-1:0]  worker_lane;
        logic [ID_W-1:0]    granted_id;
        logic [2:0]         status;
    } alloc_reply_t;

    // mirror of the allocator state and the results it owes
    class id_pool_tracker;
        bit [ID_W-1:0]   free_ring [POOL_SIZE];
        bit              free_map  [POOL_SIZE];
        bit [ID_W-1:0]   head;
        bit [ID_W-1:0]   tail;
        bit [FREE_W-1:0] free_total;
        bit [CONN_W-1:0] connected;
        bit [TOT_W-1:0]  conn_total;
        bit [TOT_W-1:0]  disc_total;
        bit [TOT_W-1:0]  retrans_total;
        bit              pool_on;
        bit [7:0]        lanes;
        alloc_reply_t    due_replies[$];
        int              mismatches;
        int              checked;
        int              grants;
        int              empties;
        int              not_ready;
        int              good_releases;
        int              refused_releases;
        int              peak_connected;

        function new();
            for (int i = 0; i < POOL_SIZE; i++) begin
                free_ring[i] = ID_W'(i);
                free_map[i]  = 1'b1;
            end
            head       = '0;
            tail       = '0;
            free_total = FREE_FULL;
            pool_on    = 1'b1;
            lanes      = 8'd1;
        endfunction

        function bit [ID_W-1:0] next_slot(bit [ID_W-1:0] pos);
            return (pos == LAST_SLOT) ? '0 : pos + 1'b1;
        endfunction

        function void note_config(logic [7:0] index, logic [7:0] value);
            if (index == CFG_POOL_ENABLED) begin
                pool_on = value[0];
            end else if (index == CFG_WORKER_COUNT) begin
                lanes = value;
            end
        endfunction

        // predict the result of one accepted request and advance the mirror
        function void note_request(sess_req_t r);
            alloc_reply_t    exp;
            bit [ID_W-1:0]   id;
            exp        = '0;
            exp.status = STS_OK;
            case (r.action)
                ACT_ACQUIRE: begin
                    if (!pool_on) begin
                        exp.status = STS_NOT_READY;
                        not_ready++;
                    end else if (free_total == 0) begin
                        exp.status = STS_EMPTY;
                        empties++;
                    end else begin
                        id = free_ring[head];
                        head = next_slot(head);
                        free_total--;
                        free_map[id] = 1'b0;
                        exp.granted_id  = id;
                        exp.worker_lane = (lanes != 0) ? LANE_W'(id % lanes) : '0;
                        grants++;
                    end
                end
                ACT_RELEASE: begin
                    if (r.body.sid >= SID_LIMIT) begin
                        exp.status = STS_BAD_ID;
                    end else if (!r.body.releasing) begin
                        exp.status = STS_NOT_RELEASING;
                    end else if (free_map[r.body.sid[ID_W-1:0]]) begin
                        exp.status = STS_ALREADY_FREE;
                    end else begin
                        free_ring[tail] = r.body.sid[ID_W-1:0];
                        tail = next_slot(tail);
                        free_total++;
                        free_map[r.body.sid[ID_W-1:0]] = 1'b1;
                        // counters move only for real disconnect reasons
                        if (r.body.reason == RSN_RETRANS) retrans_total++;
                        if (r.body.reason == RSN_NORMAL || r.body.reason == RSN_ERROR ||
                            r.body.reason == RSN_RETRANS) begin
                            if (connected != 0) connected--;
                            disc_total++;
                        end
                    end
                    if (exp.status == STS_OK) good_releases++;
                    else refused_releases++;
                end
                ACT_CONNECT: begin
                    if (connected != CONN_MAX) connected++;
                    conn_total++;
                end
                ACT_QUERY: begin
                    if (r.body.sid < SID_LIMIT) exp.id_is_free = free_map[r.body.sid[ID_W-1:0]];
                end
                ACT_CLOSE: begin
                    connected = '0;
                end
                default: begin
                end
            endcase
            exp.free_count           = free_total;
            exp.connected_count      = connected;
            exp.total_connected      = conn_total;
            exp.total_disconnected   = disc_total;
            exp.retrans_disconnected = retrans_total;
            if (int'(connected) > peak_connected) peak_connected = int'(connected);
            due_replies.push_back(exp);
        endfunction

        function void compare_field(string name, logic [TOT_W-1:0] want, logic [TOT_W-1:0] seen);
            if (seen !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_reply(alloc_reply_t got);
            alloc_reply_t exp;
            if (due_replies.size() == 0) begin
                $error("result word with no request outstanding: %h", got);
                mismatches++;
                return;
            end
            exp = due_replies[0];
            due_replies.delete(0);
            checked++;
            compare_field("status", TOT_W'(exp.status), TOT_W'(got.status));
            compare_field("granted_id", TOT_W'(exp.granted_id), TOT_W'(got.granted_id));
            compare_field("worker_lane", TOT_W'(exp.worker_lane), TOT_W'(got.worker_lane));
            compare_field("id_is_free", TOT_W'(exp.id_is_free), TOT_W'(got.id_is_free));
            compare_field("free_count", TOT_W'(exp.free_count), TOT_W'(got.free_count));
            compare_field("connected_count", TOT_W'(exp.connected_count),
                          TOT_W'(got.connected_count));
            compare_field("total_connected", exp.total_connected, got.total_connected);
            compare_field("total_disconnected", exp.total_disconnected,
                          got.total_disconnected);
            compare_field("retrans_disconnected", exp.retrans_disconnected,
                          got.retrans_disconnected);
        endfunction

        // some id currently handed out, or -1 when none is
        function int pick_held();
            int start;
            start = $urandom_range(POOL_SIZE - 1);
            for (int k = 0; k < POOL_SIZE; k++) begin
                if (!free_map[(start + k) % POOL_SIZE]) return (start + k) % POOL_SIZE;
            end
            return -1;
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    bit                   quiet_mode   = 1'b0;
    bit                   hold_ticket  = 1'b0;
    bit                   hold_seen    = 1'b0;
    int                   stall_left   = 0;
    id_pool_tracker       pool;

    session_id_free_list_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // watch every handshake at the rising edge
    always @(posedge aclk) begin
        sess_req_t req;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) pool.note_config(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                req.action = s_tuser;
                req.body   = sess_word_t'(s_tdata);
                pool.note_request(req);
            end
            if (m_tvalid && m_tready) pool.check_reply(alloc_reply_t'(m_tdata));
        end
    end

    // result side: random stalls, quiet stretches and one long hold-off
    always @(negedge aclk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen  <= hold_ticket;
            stall_left <= HOLD_OFF_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet_mode && $urandom_range(99) < IDLE_PERCENT) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one request word; called and left at a falling edge
    task automatic send_fields(input logic [2:0] action, input logic [15:0] sid,
                               input logic releasing, input logic [2:0] reason);
        sess_word_t body;
        body.pad       = '0;
        body.reason    = reason;
        body.releasing = releasing;
        body.sid       = sid;
        if (!quiet_mode && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tuser  <= action;
        s_tdata  <= body;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // action with random content in the fields it ignores
    task automatic send_action(input logic [2:0] action);
        send_fields(action, 16'($urandom), 1'($urandom), 3'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pool.due_replies.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [7:0] index, input logic [7:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // both registers, written only with nothing in flight
    task automatic set_pool(input bit enabled, input logic [7:0] lanes);
        wait_drained();
        put_reg(CFG_POOL_ENABLED, {7'd0, enabled});
        put_reg(CFG_WORKER_COUNT, lanes);
        cfg_valid <= 1'b0;
    endtask

    // mostly acquire and well-formed release, the rest connects, queries, closes and noise
    task automatic random_burst(input int count);
        int         roll;
        int         held;
        logic [2:0] reason;
        for (int n = 0; n < count; n++) begin
            roll   = $urandom_range(99);
            held   = pool.pick_held();
            reason = ($urandom_range(99) < 70) ? 3'($urandom_range(RSN_NORMAL, RSN_RETRANS))
                                               : 3'($urandom);
            if (roll < 35 || (roll < 65 && held < 0)) begin
                send_action(ACT_ACQUIRE);
            end else if (roll < 65) begin
                send_fields(ACT_RELEASE, 16'(held), 1'b1, reason);
            end else if (roll < 75) begin
                send_action(ACT_CONNECT);
            end else if (roll < 85) begin
                send_fields(ACT_QUERY,
                            $urandom_range(1) ? 16'($urandom_range(POOL_SIZE - 1))
                                              : 16'($urandom),
                            1'($urandom), 3'($urandom));
            end else if (roll < 88) begin
                send_action(ACT_CLOSE);
            end else if (roll < 92) begin
                send_action(ACT_RELEASE);
            end else if (roll < 95 && held >= 0) begin
                send_fields(ACT_RELEASE, 16'(held), 1'b0, reason);
            end else if (roll < 97) begin
                send_fields(ACT_RELEASE, 16'($urandom_range(POOL_SIZE - 1)), 1'b1, reason);
            end else begin
                send_action(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)));
            end
        end
    endtask

    // hand every outstanding id back in shuffled order
    task automatic refill_pool();
        int held_ids[$];
        int j;
        int swap;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (!pool.free_map[i]) held_ids.push_back(i);
        end
        for (int k = held_ids.size() - 1; k > 0; k--) begin
            j           = $urandom_range(k);
            swap        = held_ids[k];
            held_ids[k] = held_ids[j];
            held_ids[j] = swap;
        end
        foreach (held_ids[k]) send_fields(ACT_RELEASE, 16'(held_ids[k]), 1'b1, 3'($urandom));
    endtask

    // opening sequence on reset settings: one lane, pool enabled
    task automatic directed_opening();
        send_fields(ACT_QUERY, 16'd0, 1'b0, RSN_NONE);
        send_fields(ACT_QUERY, 16'(LAST_SLOT), 1'b1, RSN_BAD_LAST);
        send_fields(ACT_QUERY, SID_LIMIT, 1'b0, RSN_NONE);
        send_fields(ACT_ACQUIRE, 16'hFFFF, 1'b1, RSN_BAD_LAST);
        send_fields(ACT_ACQUIRE, 16'd0, 1'b0, RSN_NONE);
        send_fields(ACT_QUERY, 16'd1, 1'b1, RSN_NORMAL);
        // release refusals: flag clear, out of range, range beats flag, already-free id
        send_fields(ACT_RELEASE, 16'd0, 1'b0, RSN_NORMAL);
        send_fields(ACT_RELEASE, 16'hFFFF, 1'b1, RSN_NORMAL);
        send_fields(ACT_RELEASE, SID_LIMIT, 1'b0, RSN_NORMAL);
        send_fields(ACT_RELEASE, 16'd5, 1'b1, RSN_NORMAL);
        send_action(ACT_CONNECT);
        send_action(ACT_CONNECT);
        send_fields(ACT_RELEASE, 16'd0, 1'b1, RSN_NORMAL);
        send_fields(ACT_RELEASE, 16'd1, 1'b1, RSN_RETRANS);
        // error disconnect with nobody connected stays at zero
        send_action(ACT_ACQUIRE);
        send_fields(ACT_RELEASE, 16'd2, 1'b1, RSN_ERROR);
        // reasons that leave the counters alone
        send_action(ACT_ACQUIRE);
        send_fields(ACT_RELEASE, 16'd3, 1'b1, RSN_ABORT);
        send_action(ACT_ACQUIRE);
        send_fields(ACT_RELEASE, 16'd4, 1'b1, RSN_NONE);
        send_action(ACT_ACQUIRE);
        send_fields(ACT_RELEASE, 16'd5, 1'b1, RSN_BAD_LAST);
        send_action(ACT_CLOSE);
        send_action(ACT_SPARE_FIRST);
        send_action(ACT_SPARE_LAST);
    endtask

    initial begin
        pool = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_opening();

        // wide lane divisor, first with no idling anywhere
        set_pool(1'b1, 8'd255);
        quiet_mode <= 1'b1;
        random_burst(60);
        quiet_mode <= 1'b0;
        random_burst(40);

        // result side holds off while requests keep coming
        hold_ticket <= ~hold_ticket;
        random_burst(40);

        // sender pauses until everything has come back
        wait_drained();
        random_burst(30);

        // zero lanes, then a disabled pool where releases still go through
        set_pool(1'b1, 8'd0);
        random_burst(40);
        set_pool(1'b0, 8'd7);
        random_burst(30);
        set_pool(1'b1, 8'd7);
        random_burst(40);
        set_pool(1'b1, 8'($urandom_range(1, 255)));
        random_burst(40);

        // disabled pool refuses acquire, queries still answer
        set_pool(1'b0, 8'd128);
        send_action(ACT_ACQUIRE);
        send_action(ACT_QUERY);

        // hand back every held id in shuffled order, then more traffic
        set_pool(1'b1, 8'd3);
        refill_pool();
        random_burst(50);

        send_action(ACT_CONNECT);
        send_action(ACT_ACQUIRE);
        send_action(ACT_CLOSE);

        wait_drained();
        $display("checked %0d result words: %0d grants, %0d empty, %0d not ready",
                 pool.checked, pool.grants, pool.empties, pool.not_ready);
        $display("%0d releases taken, %0d refused, connected count peaked at %0d",
                 pool.good_releases, pool.refused_releases, pool.peak_connected);
        if (pool.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop for a hung handshake
    initial begin
        #(RUN_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule
